[sv/bsr_pkg.sv]
// Package for the bracketed root search sequencer.
// Widths, register indexes, status codes and saturating helpers.
// No dependencies.
`timescale 1ns / 1ps

package bsr_pkg;

    localparam int DATA_W   = 32;
    localparam int CFG_W    = 31;
    localparam int CNT_W    = 16;
    localparam int ITER_W   = 8;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W   = 63;
    localparam int DIVD_W   = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_USE_BISECT = 3'd5;

    localparam logic [1:0] ST_EVAL      = 2'd0;
    localparam logic [1:0] ST_CONVERGED = 2'd1;
    localparam logic [1:0] ST_NO_CHANGE = 2'd2;
    localparam logic [1:0] ST_ITER_LIM  = 2'd3;

    localparam logic [CFG_W-1:0]  RST_STEP_SIZE  = 31'd65536;
    localparam logic [CFG_W-1:0]  RST_MAX_LENGTH = 31'd524288;
    localparam logic [CFG_W-1:0]  RST_TOLERANCE  = 31'd66;
    localparam logic [CNT_W-1:0]  RST_STEP_COUNT = 16'd8;
    localparam logic [ITER_W-1:0] RST_MAX_ITER   = 8'd50;

    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // saturate a sum that grew by one bit
    function automatic logic signed [DATA_W-1:0] sat1(input logic signed [DATA_W:0] s);
        logic signed [DATA_W-1:0] r;
        if (s[DATA_W] != s[DATA_W-1])
            r = s[DATA_W] ? VAL_MIN : VAL_MAX;
        else
            r = s[DATA_W-1:0];
        return r;
    endfunction

    // negate when flip is set, saturating the most negative value
    function automatic logic signed [DATA_W-1:0] orient(input logic flip,
                                                        input logic signed [DATA_W-1:0] x);
        logic signed [DATA_W-1:0] r;
        if (!flip)
            r = x;
        else if (x == VAL_MIN)
            r = VAL_MAX;
        else
            r = -x;
        return r;
    endfunction

endpackage

[sv/bsr_if.sv]
// Handshake interfaces for the request and response channels.
// Depends on bsr_pkg for field widths.
`timescale 1ns / 1ps

interface bsr_req_if;
    logic                                valid;
    logic                                ready;
    logic                                operation;
    logic signed [bsr_pkg::DATA_W-1:0]   value;
    modport source (output valid, operation, value, input ready);
    modport sink   (input valid, operation, value, output ready);
endinterface

interface bsr_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          status;
    logic signed [bsr_pkg::DATA_W-1:0]   point;
    modport source (output valid, status, point, input ready);
    modport sink   (input valid, status, point, output ready);
endinterface

[sv/bsr_div.sv]
// Restoring divider, one quotient bit per cycle.
// Depends on bsr_pkg for widths.
`timescale 1ns / 1ps

module bsr_div
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [bsr_pkg::DIVD_W-1:0]        dividend,
    input  logic [bsr_pkg::DATA_W-1:0]        divisor,
    output logic                              done,
    output logic [bsr_pkg::DIVD_W-1:0]        quotient
);

    localparam int CW = $clog2(bsr_pkg::DIVD_W);
    localparam logic [CW-1:0] LAST = CW'(bsr_pkg::DIVD_W - 1);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic [bsr_pkg::DATA_W-1:0]    rem_reg, rem_next;
    logic [bsr_pkg::DIVD_W-1:0]    dq_reg, dq_next;
    logic [bsr_pkg::DATA_W:0]      shifted;
    logic                          take;

    assign shifted = {rem_reg, dq_reg[bsr_pkg::DIVD_W-1]};
    assign take    = shifted >= {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dq_next   = dividend;
        end
        else if (busy_reg)
        begin
            rem_next = take ? bsr_pkg::DATA_W'(shifted - {1'b0, divisor})
                            : shifted[bsr_pkg::DATA_W-1:0];
            dq_next  = {dq_reg[bsr_pkg::DIVD_W-2:0], take};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

[sv/bracketed_root_search_sequencer.sv]
// Top level of the bracketed root search sequencer.
// Depends on bsr_pkg, bsr_req_if / bsr_rsp_if and bsr_div.
//
//   channel  dir  payload                  meaning
//   req      in   operation, value         start (origin value) or returned value
//   rsp      out  status, point            evaluate request or final estimate
//   cfg      in   cfg_we, cfg_index, data  register writes
//
// Each word passes IDLE, DECIDE and DONE; an outward step adds MUL and POST, a
// bisection step PREP, EST and CHK, and a regula falsi step PREP, MUL, POST, the
// divider wait DIV, EST and CHK. A found bracket adds MUL and POST before PREP.
// One word is processed at a time.
// Reset clears control state and loads the register defaults.
// A result waits in the output register; the next word is taken only after
// it has been handed over to that register.
`timescale 1ns / 1ps

module bracketed_root_search_sequencer
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bsr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bsr_pkg::CFG_W-1:0]           cfg_data,
    bsr_req_if.sink                             req,
    bsr_rsp_if.source                           rsp
);

    localparam int W  = bsr_pkg::DATA_W;
    localparam int CW = bsr_pkg::CFG_W;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECIDE = 9'b000000010,
        S_MUL    = 9'b000000100,
        S_POST   = 9'b000001000,
        S_PREP   = 9'b000010000,
        S_DIV    = 9'b000100000,
        S_EST    = 9'b001000000,
        S_CHK    = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_STEP   = 3'b010,
        PH_REFINE = 3'b100
    } phase_t;

    typedef enum logic [2:0] {
        K_LAMBDA = 3'b001,
        K_LOW    = 3'b010,
        K_RF     = 3'b100
    } kind_t;

    // configuration
    logic [CW-1:0]                    step_size_reg, max_length_reg, tolerance_reg;
    logic [bsr_pkg::CNT_W-1:0]        step_count_reg;
    logic [bsr_pkg::ITER_W-1:0]       max_iter_reg;
    logic                             use_bis_reg;

    state_t st_reg, st_next;
    phase_t phase_reg, phase_next;
    kind_t  kind_reg, kind_next;

    logic                             op_reg, op_next;
    logic signed [W-1:0]              val_reg, val_next;
    logic [bsr_pkg::CNT_W-1:0]        si_reg, si_next;
    logic [bsr_pkg::ITER_W-1:0]       iter_reg, iter_next;
    logic                             flip_reg, flip_next;
    logic signed [W-1:0]              bl_reg, bl_next, bh_reg, bh_next;
    logic signed [W-1:0]              vl_reg, vl_next, vh_reg, vh_next;
    logic signed [W-1:0]              pv_reg, pv_next, pe_reg, pe_next;
    logic signed [W-1:0]              pend_reg, pend_next, est_reg, est_next;
    logic [W-1:0]                     mul_a_reg, mul_a_next;
    logic [CW-1:0]                    mul_b_reg, mul_b_next;
    logic [bsr_pkg::PROD_W-1:0]       prod_reg, prod_next;
    logic [W-1:0]                     d_reg, d_next;
    logic                             rhas_reg, rhas_next;
    logic [1:0]                       rstat_reg, rstat_next;
    logic signed [W-1:0]              rpt_reg, rpt_next;
    logic                             ov_reg, ov_next;
    logic [1:0]                       ostat_reg, ostat_next;
    logic signed [W-1:0]              opt_reg, opt_next;

    logic                             div_start, div_done;
    logic [bsr_pkg::DIVD_W-1:0]       quot;

    // shared combinational terms
    logic signed [W-1:0]              ml_s, z, sat2ml;
    logic [W-1:0]                     ml2;
    logic [CW-1:0]                    sat_prod, min_step;
    logic signed [W:0]                span, vh_mag, bsum, rf_sum, dif, adif;
    logic [CW-1:0]                    qc;

    assign ml_s     = {1'b0, max_length_reg};
    assign z        = bsr_pkg::orient(flip_reg, val_reg);
    assign ml2      = {max_length_reg, 1'b0};
    assign sat2ml   = ml2[W-1] ? bsr_pkg::VAL_MAX : $signed(ml2);
    assign sat_prod = (|prod_reg[bsr_pkg::PROD_W-1:CW]) ? {CW{1'b1}} : prod_reg[CW-1:0];
    assign min_step = (step_size_reg < max_length_reg) ? step_size_reg : max_length_reg;
    assign span     = {bh_reg[W-1], bh_reg} - {bl_reg[W-1], bl_reg};
    assign vh_mag   = vh_reg[W-1] ? -{vh_reg[W-1], vh_reg} : {vh_reg[W-1], vh_reg};
    assign bsum     = {bl_reg[W-1], bl_reg} + {bh_reg[W-1], bh_reg};
    assign qc       = (|quot[bsr_pkg::DIVD_W-1:CW]) ? {CW{1'b1}} : quot[CW-1:0];
    assign rf_sum   = (bh_reg < bl_reg) ? {bl_reg[W-1], bl_reg} - {2'b00, qc}
                                        : {bl_reg[W-1], bl_reg} + {2'b00, qc};
    assign dif      = {pe_reg[W-1], pe_reg} - {est_reg[W-1], est_reg};
    assign adif     = dif[W] ? -dif : dif;

    assign div_start = (st_reg == S_POST) && (kind_reg == K_RF) && (d_reg != '0);

    bsr_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({1'b0, prod_reg}),
        .divisor  (d_reg),
        .done     (div_done),
        .quotient (quot)
    );

    always_comb
    begin
        st_next    = st_reg;
        phase_next = phase_reg;
        kind_next  = kind_reg;
        op_next    = op_reg;
        val_next   = val_reg;
        si_next    = si_reg;
        iter_next  = iter_reg;
        flip_next  = flip_reg;
        bl_next    = bl_reg;
        bh_next    = bh_reg;
        vl_next    = vl_reg;
        vh_next    = vh_reg;
        pv_next    = pv_reg;
        pe_next    = pe_reg;
        pend_next  = pend_reg;
        est_next   = est_reg;
        mul_a_next = mul_a_reg;
        mul_b_next = mul_b_reg;
        prod_next  = prod_reg;
        d_next     = d_reg;
        rhas_next  = rhas_reg;
        rstat_next = rstat_reg;
        rpt_next   = rpt_reg;
        ov_next    = ov_reg && !rsp.ready;
        ostat_next = ostat_reg;
        opt_next   = opt_reg;

        case (st_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next  = req.operation;
                    val_next = req.value;
                    st_next  = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                rhas_next = 1'b0;
                st_next   = S_DONE;
                if (!op_reg)
                begin
                    flip_next = val_reg[W-1];
                    pv_next   = bsr_pkg::orient(val_reg[W-1], val_reg);
                    iter_next = '0;
                    rhas_next = 1'b1;
                    if (step_count_reg == '0)
                    begin
                        phase_next = PH_IDLE;
                        si_next    = '0;
                        rstat_next = bsr_pkg::ST_NO_CHANGE;
                        rpt_next   = ml_s;
                    end
                    else
                    begin
                        phase_next = PH_STEP;
                        si_next    = 16'd1;
                        pend_next  = {1'b0, min_step};
                        rstat_next = bsr_pkg::ST_EVAL;
                        rpt_next   = {1'b0, min_step};
                    end
                end
                else if (phase_reg == PH_STEP)
                begin
                    if (z[W-1])
                    begin
                        // sign flipped: bracket is [previous step, this step]
                        bh_next    = pend_reg;
                        vh_next    = z;
                        vl_next    = pv_reg;
                        iter_next  = '0;
                        pe_next    = sat2ml;
                        mul_a_next = W'(si_reg - 1'b1);
                        mul_b_next = step_size_reg;
                        kind_next  = K_LOW;
                        st_next    = S_MUL;
                    end
                    else
                    begin
                        pv_next = z;
                        if (si_reg >= step_count_reg)
                        begin
                            phase_next = PH_IDLE;
                            rhas_next  = 1'b1;
                            rstat_next = bsr_pkg::ST_NO_CHANGE;
                            rpt_next   = ml_s;
                        end
                        else
                        begin
                            si_next    = si_reg + 1'b1;
                            mul_a_next = W'(si_reg + 1'b1);
                            mul_b_next = step_size_reg;
                            kind_next  = K_LAMBDA;
                            st_next    = S_MUL;
                        end
                    end
                end
                else if (phase_reg == PH_REFINE)
                begin
                    if (z[W-1])
                    begin
                        bh_next = pend_reg;
                        vh_next = z;
                    end
                    else
                    begin
                        bl_next = pend_reg;
                        vl_next = z;
                    end
                    pe_next = pend_reg;
                    if (iter_reg >= max_iter_reg)
                    begin
                        phase_next = PH_IDLE;
                        rhas_next  = 1'b1;
                        rstat_next = bsr_pkg::ST_ITER_LIM;
                        rpt_next   = pend_reg;
                    end
                    else
                        st_next = S_PREP;
                end
            end
            S_MUL:
            begin
                prod_next = mul_a_reg * mul_b_reg;
                st_next   = S_POST;
            end
            S_POST:
            begin
                case (kind_reg)
                    K_LAMBDA:
                    begin
                        pend_next  = (sat_prod < max_length_reg) ? {1'b0, sat_prod} : ml_s;
                        rhas_next  = 1'b1;
                        rstat_next = bsr_pkg::ST_EVAL;
                        rpt_next   = (sat_prod < max_length_reg) ? {1'b0, sat_prod} : ml_s;
                        st_next    = S_DONE;
                    end
                    K_LOW:
                    begin
                        bl_next = {1'b0, sat_prod};
                        if (max_iter_reg == '0)
                        begin
                            phase_next = PH_IDLE;
                            rhas_next  = 1'b1;
                            rstat_next = bsr_pkg::ST_ITER_LIM;
                            rpt_next   = '0;
                            st_next    = S_DONE;
                        end
                        else
                        begin
                            phase_next = PH_REFINE;
                            st_next    = S_PREP;
                        end
                    end
                    default:
                        st_next = (d_reg == '0) ? S_EST : S_DIV;
                endcase
            end
            S_PREP:
            begin
                if (use_bis_reg)
                    st_next = S_EST;
                else
                begin
                    // low side value is never negative after orientation
                    mul_a_next = span[W] ? W'(-span) : span[W-1:0];
                    mul_b_next = vl_reg[CW-1:0];
                    d_next     = W'({1'b0, vl_reg} + vh_mag);
                    kind_next  = K_RF;
                    st_next    = S_MUL;
                end
            end
            S_DIV:
            begin
                if (div_done)
                    st_next = S_EST;
            end
            S_EST:
            begin
                if (use_bis_reg)
                    est_next = bsum[W:1];
                else if (d_reg == '0)
                    est_next = bl_reg;
                else
                    est_next = bsr_pkg::sat1(rf_sum);
                st_next = S_CHK;
            end
            S_CHK:
            begin
                rhas_next = 1'b1;
                rpt_next  = est_reg;
                if (adif <= $signed({2'b00, tolerance_reg}))
                begin
                    phase_next = PH_IDLE;
                    rstat_next = bsr_pkg::ST_CONVERGED;
                end
                else
                begin
                    pend_next  = est_reg;
                    iter_next  = iter_reg + 1'b1;
                    rstat_next = bsr_pkg::ST_EVAL;
                end
                st_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    st_next = S_IDLE;
                    if (rhas_reg)
                    begin
                        ov_next    = 1'b1;
                        ostat_next = rstat_reg;
                        opt_next   = rpt_reg;
                    end
                end
            end
            default:
                st_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_size_reg  <= bsr_pkg::RST_STEP_SIZE;
            max_length_reg <= bsr_pkg::RST_MAX_LENGTH;
            tolerance_reg  <= bsr_pkg::RST_TOLERANCE;
            step_count_reg <= bsr_pkg::RST_STEP_COUNT;
            max_iter_reg   <= bsr_pkg::RST_MAX_ITER;
            use_bis_reg    <= 1'b0;
            st_reg         <= S_IDLE;
            phase_reg      <= PH_IDLE;
            kind_reg       <= K_LAMBDA;
            si_reg         <= '0;
            iter_reg       <= '0;
            flip_reg       <= 1'b0;
            rhas_reg       <= 1'b0;
            ov_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    bsr_pkg::CFG_STEP_SIZE:  step_size_reg  <= cfg_data;
                    bsr_pkg::CFG_MAX_LENGTH: max_length_reg <= cfg_data;
                    bsr_pkg::CFG_TOLERANCE:  tolerance_reg  <= cfg_data;
                    bsr_pkg::CFG_STEP_COUNT: step_count_reg <= cfg_data[bsr_pkg::CNT_W-1:0];
                    bsr_pkg::CFG_MAX_ITER:   max_iter_reg   <= cfg_data[bsr_pkg::ITER_W-1:0];
                    bsr_pkg::CFG_USE_BISECT: use_bis_reg    <= cfg_data[0];
                    default: ;
                endcase
            end
            st_reg    <= st_next;
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            si_reg    <= si_next;
            iter_reg  <= iter_next;
            flip_reg  <= flip_next;
            rhas_reg  <= rhas_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        val_reg   <= val_next;
        bl_reg    <= bl_next;
        bh_reg    <= bh_next;
        vl_reg    <= vl_next;
        vh_reg    <= vh_next;
        pv_reg    <= pv_next;
        pe_reg    <= pe_next;
        pend_reg  <= pend_next;
        est_reg   <= est_next;
        mul_a_reg <= mul_a_next;
        mul_b_reg <= mul_b_next;
        prod_reg  <= prod_next;
        d_reg     <= d_next;
        rstat_reg <= rstat_next;
        rpt_reg   <= rpt_next;
        ostat_reg <= ostat_next;
        opt_reg   <= opt_next;
    end

    assign req.ready  = (st_reg == S_IDLE);
    assign rsp.valid  = ov_reg;
    assign rsp.status = ostat_reg;
    assign rsp.point  = opt_reg;

    // a new result only comes out of the hand-off state
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(st_reg == S_DONE))
        else $error("response raised outside hand-off");

    // the divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (st_reg == S_DIV))
        else $error("divider done outside wait state");

    // a final status always leaves the search idle
    a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_DONE && rhas_reg && rstat_reg != bsr_pkg::ST_EVAL)
        |-> (phase_reg == PH_IDLE))
        else $error("final status while search active");

endmodule
